// ===== hw/rtl/gmorph_pkg.sv =====
package gmorph_pkg;

   localparam int PIXEL_W = 8;
   localparam int COORD_W = 11;
   localparam int CFG_W   = 12;
   localparam int CSR_INDEX_W = 2;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CFG_W-1:0]   cfg_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_ERODE_MODE   = 2'd2
   } csr_index_type;

   localparam cfg_type   WIDTH_RESET  = 12'd640;
   localparam cfg_type   HEIGHT_RESET = 12'd480;
   localparam pixel_type PIXEL_MAX    = 8'd255;
   localparam pixel_type PIXEL_MIN    = 8'd0;

endpackage

// ===== hw/rtl/gray_morphology_3x3.sv =====
// 3x3 grayscale dilation / erosion over a raster-order pixel stream.
// req channel: one 8-bit pixel per item, frames in raster order. rsp channel:
// one item per output pixel with its value, column, row, a flag on the last
// result caused by one input pixel and a flag on the frame's final pixel.
// csr port: index 0 frame width, 1 frame height, 2 erode mode (1 = minimum).
// Writing width or height restarts the frame at (0,0); write only while idle.
// A pixel's first result passes the line buffer read at acceptance, the window
// update, then the neighborhood reduction into the output register. Throughput
// is one pixel per clock while rsp_stall is low and a pixel causes one result at
// most; the line buffer's one read and one write per clock and the
// one-result-per-cycle reducer set that figure. The pixel that ends a row below
// the first causes two results, each pixel of the last row but its first causes
// two, and the frame's final pixel causes four; req_stall is held for the extra
// cycles. When rsp_stall is high the output register holds its item and the
// pipeline behind it fills, then req_stall rises.
// Reset: synchronous, clears pipeline valids, position counters and the
// registers (640 x 480, dilation). Line buffer contents are not cleared;
// rows above the frame are masked out.
module gray_morphology_3x3 #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gmorph_pkg::pixel_type               req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gmorph_pkg::pixel_type               rsp_result_value,
   output gmorph_pkg::coord_type               rsp_out_col,
   output gmorph_pkg::coord_type               rsp_out_row,
   output logic                                rsp_last_of_run,
   output logic                                rsp_frame_end,
   input  logic                                csr_write,
   input  logic [gmorph_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  gmorph_pkg::cfg_type                 csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int PW  = gmorph_pkg::PIXEL_W;
   localparam int SWW = (CW + 1 > gmorph_pkg::CFG_W) ? CW + 1 : gmorph_pkg::CFG_W;
   localparam int SWH = (RW + 1 > gmorph_pkg::CFG_W) ? RW + 1 : gmorph_pkg::CFG_W;

   // configuration
   gmorph_pkg::cfg_type width_ff, height_ff;
   logic                erode_ff;

   logic [SWW-1:0] w_ext;
   logic [SWH-1:0] h_ext;
   logic [CW-1:0]  w_last;
   logic [RW-1:0]  h_last;

   assign w_ext = SWW'(width_ff);
   assign h_ext = SWH'(height_ff);

   always_comb begin
      if (w_ext == '0) begin
         w_last = '0;
      end else if (w_ext > SWW'(MAX_WIDTH)) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(w_ext - SWW'(1));
      end
      if (h_ext == '0) begin
         h_last = '0;
      end else if (h_ext > SWH'(MAX_HEIGHT)) begin
         h_last = RW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RW'(h_ext - SWH'(1));
      end
   end

   // pipeline handshake
   logic b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic out_free, c_last, c_emit, c_done, c_free, b_adv, b_free, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign c_emit    = c_valid_ff && out_free;
   assign c_done    = c_emit && c_last;
   assign c_free    = !c_valid_ff || c_done;
   assign b_adv     = b_valid_ff && c_free;
   assign b_free    = !b_valid_ff || c_free;
   assign accept    = req_valid && b_free;
   assign req_stall = !b_free;

   // position counters
   logic [CW-1:0] col_ff, col_in, x_cur;
   logic [RW-1:0] row_ff, row_in, y_cur;

   assign x_cur = (col_ff > w_last) ? '0 : col_ff;
   assign y_cur = (row_ff > h_last) ? '0 : row_ff;

   always_comb begin
      if (x_cur == w_last) begin
         col_in = '0;
         row_in = (y_cur == h_last) ? '0 : y_cur + RW'(1);
      end else begin
         col_in = x_cur + CW'(1);
         row_in = y_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gmorph_pkg::WIDTH_RESET;
         height_ff <= gmorph_pkg::HEIGHT_RESET;
         erode_ff  <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            gmorph_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= csr_data;
               col_ff   <= '0;
               row_ff   <= '0;
            end
            gmorph_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= csr_data;
               col_ff    <= '0;
               row_ff    <= '0;
            end
            gmorph_pkg::CSR_ERODE_MODE: begin
               erode_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: [2*PW-1:PW] two rows above, [PW-1:0] one row above
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_ff, fwd_data_ff, line_eff, line_wr;
   logic            b_fwd_ff, fwd_in;
   logic [CW-1:0]   b_x_ff;
   logic [RW-1:0]   b_y_ff;
   gmorph_pkg::pixel_type b_pixel_ff;

   assign line_eff = b_fwd_ff ? fwd_data_ff : rd_ff;
   assign line_wr  = {line_eff[PW-1:0], b_pixel_ff};
   assign fwd_in   = b_adv && (b_x_ff == x_cur);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[x_cur];
      end
      if (b_adv) begin
         line_mem[b_x_ff] <= line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_x_ff      <= x_cur;
         b_y_ff      <= y_cur;
         b_pixel_ff  <= req_pixel;
         b_fwd_ff    <= fwd_in;
         fwd_data_ff <= line_wr;
      end
   end

   // 3x3 window: row 0 two rows above, column 2 newest
   gmorph_pkg::pixel_type window_ff [3][3];

   always_ff @(posedge clock) begin
      if (b_adv) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r][0] <= window_ff[r][1];
            window_ff[r][1] <= window_ff[r][2];
         end
         window_ff[0][2] <= line_eff[2*PW-1:PW];
         window_ff[1][2] <= line_eff[PW-1:0];
         window_ff[2][2] <= b_pixel_ff;
      end
   end

   // result sequencer
   logic          c_has_r0, c_has_r1, c_has_c0, c_has_c1;
   logic          c_has_r1_ff, c_has_c0_ff, c_has_c1_ff;
   logic          c_rsel_ff, c_csel_ff;
   logic          c_y_ge1_ff, c_y_ge2_ff, c_x_ge1_ff, c_x_ge2_ff;
   logic [CW-1:0] c_x_ff;
   logic [RW-1:0] c_y_ff;

   assign c_has_r0 = (b_y_ff != '0);
   assign c_has_r1 = (b_y_ff == h_last);
   assign c_has_c0 = (b_x_ff != '0);
   assign c_has_c1 = (b_x_ff == w_last);
   assign c_last   = (c_csel_ff || !c_has_c1_ff) && (c_rsel_ff || !c_has_r1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_adv) begin
         c_valid_ff <= (c_has_r0 || c_has_r1) && (c_has_c0 || c_has_c1);
      end else if (c_done) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_x_ff      <= b_x_ff;
         c_y_ff      <= b_y_ff;
         c_has_r1_ff <= c_has_r1;
         c_has_c0_ff <= c_has_c0;
         c_has_c1_ff <= c_has_c1;
         c_rsel_ff   <= !c_has_r0;
         c_csel_ff   <= !c_has_c0;
         c_y_ge1_ff  <= c_has_r0;
         c_y_ge2_ff  <= (b_y_ff > RW'(1));
         c_x_ge1_ff  <= c_has_c0;
         c_x_ge2_ff  <= (b_x_ff > CW'(1));
      end else if (c_emit && !c_last) begin
         if (!c_csel_ff && c_has_c1_ff) begin
            c_csel_ff <= 1'b1;
         end else begin
            c_csel_ff <= !c_has_c0_ff;
            c_rsel_ff <= 1'b1;
         end
      end
   end

   // neighborhood reduction
   function automatic gmorph_pkg::pixel_type pick(input gmorph_pkg::pixel_type a,
                                                  input gmorph_pkg::pixel_type b,
                                                  input logic erode);
      if (erode) begin
         pick = (b < a) ? b : a;
      end else begin
         pick = (b > a) ? b : a;
      end
   endfunction

   logic [2:0]            row_ok, col_ok;
   gmorph_pkg::pixel_type ident, result_value;
   gmorph_pkg::pixel_type masked [3][3];
   gmorph_pkg::pixel_type row_red [3];
   logic [CW-1:0]         cx;
   logic [RW-1:0]         cy;

   assign ident  = erode_ff ? gmorph_pkg::PIXEL_MAX : gmorph_pkg::PIXEL_MIN;
   assign row_ok = {1'b1, c_y_ge1_ff, !c_rsel_ff && c_y_ge2_ff};
   assign col_ok = {1'b1, c_x_ge1_ff, !c_csel_ff && c_x_ge2_ff};
   assign cx     = c_csel_ff ? c_x_ff : c_x_ff - CW'(1);
   assign cy     = c_rsel_ff ? c_y_ff : c_y_ff - RW'(1);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            masked[r][c] = (row_ok[r] && col_ok[c]) ? window_ff[r][c] : ident;
         end
         row_red[r] = pick(pick(masked[r][0], masked[r][1], erode_ff),
                           masked[r][2], erode_ff);
      end
      result_value = pick(pick(row_red[0], row_red[1], erode_ff), row_red[2], erode_ff);
   end

   // output register
   gmorph_pkg::pixel_type rsp_value_ff;
   gmorph_pkg::coord_type rsp_col_ff, rsp_row_ff;
   logic                  rsp_last_ff, rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_emit) begin
         rsp_value_ff <= result_value;
         rsp_col_ff   <= gmorph_pkg::coord_type'(cx);
         rsp_row_ff   <= gmorph_pkg::coord_type'(cy);
         rsp_last_ff  <= c_last;
         rsp_end_ff   <= (cx == w_last) && (cy == h_last);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_frame_end    = rsp_end_ff;

   // checks
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_end_ff || rsp_last_ff))
      else $error("frame end on an item that is not last of its run");

   a_forward_only_one_column: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_fwd_ff) |-> (w_last == '0 && b_x_ff == '0))
      else $error("line buffer forward taken on a row wider than one pixel");

   a_upper_row_exists: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> (c_rsel_ff || c_y_ge1_ff))
      else $error("result scheduled for a row above the frame");

   a_result_holds_under_stall: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !out_free) |=> (c_valid_ff && $stable(c_rsel_ff) && $stable(c_csel_ff)))
      else $error("result sequencer moved while output register was full");

endmodule

// ===== tb/gray_morphology_3x3_checker.sv =====
`timescale 1ns / 100ps
module gray_morphology_3x3_checker #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  gmorph_pkg::pixel_type              req_pixel,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  gmorph_pkg::pixel_type              rsp_result_value,
   input  gmorph_pkg::coord_type              rsp_out_col,
   input  gmorph_pkg::coord_type              rsp_out_row,
   input  logic                               rsp_last_of_run,
   input  logic                               rsp_frame_end,
   input  logic                               csr_write,
   input  logic [gmorph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  gmorph_pkg::cfg_type                csr_data,
   output int                                 mismatches,
   output int                                 outstanding
);

   typedef struct {
      gmorph_pkg::pixel_type value;
      gmorph_pkg::coord_type col;
      gmorph_pkg::coord_type row;
      logic                  last_of_run;
      logic                  frame_end;
   } morph_result_type;

   morph_result_type expected_results[$];

   gmorph_pkg::pixel_type line_above_mem [MAX_WIDTH] = '{default: '0};
   gmorph_pkg::pixel_type line_two_above_mem [MAX_WIDTH] = '{default: '0};
   gmorph_pkg::pixel_type window [3][3];
   int                    col_pos;
   int                    row_pos;
   gmorph_pkg::cfg_type   width_reg;
   gmorph_pkg::cfg_type   height_reg;
   logic                  erode_reg;

   function automatic int clamp_dim(gmorph_pkg::cfg_type v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic gmorph_pkg::pixel_type neighborhood_extreme(int cx, int cy,
                                                                  int x, int y,
                                                                  int w, int h);
      gmorph_pkg::pixel_type acc;
      int nr, nc, r, c;
      acc = erode_reg ? gmorph_pkg::PIXEL_MAX : gmorph_pkg::PIXEL_MIN;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            nr = cy + dy;
            nc = cx + dx;
            r = nr - y + 2;
            c = nc - x + 2;
            if (nr >= 0 && nr < h && nc >= 0 && nc < w &&
                r >= 0 && r <= 2 && c >= 0 && c <= 2) begin
               if (erode_reg ? (window[r][c] < acc) : (window[r][c] > acc))
                  acc = window[r][c];
            end
         end
      end
      return acc;
   endfunction

   task automatic apply_register(logic [gmorph_pkg::CSR_INDEX_W-1:0] index,
                                 gmorph_pkg::cfg_type data);
      case (index)
         gmorph_pkg::CSR_FRAME_WIDTH: begin
            width_reg = data;
            col_pos = 0;
            row_pos = 0;
         end
         gmorph_pkg::CSR_FRAME_HEIGHT: begin
            height_reg = data;
            col_pos = 0;
            row_pos = 0;
         end
         gmorph_pkg::CSR_ERODE_MODE: begin
            erode_reg = data[0];
         end
         default: ;
      endcase
   endtask

   task automatic predict_neighborhoods(gmorph_pkg::pixel_type p);
      int w, h, x, y;
      int rows[$];
      int cols[$];
      morph_result_type res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = line_two_above_mem[x];
      window[1][2] = line_above_mem[x];
      window[2][2] = p;
      line_two_above_mem[x] = line_above_mem[x];
      line_above_mem[x] = p;
      if (y >= 1) rows.push_back(y - 1);
      if (y == h - 1) rows.push_back(y);
      if (x >= 1) cols.push_back(x - 1);
      if (x == w - 1) cols.push_back(x);
      foreach (rows[i]) begin
         foreach (cols[j]) begin
            res.value = neighborhood_extreme(cols[j], rows[i], x, y, w, h);
            res.col = gmorph_pkg::coord_type'(cols[j]);
            res.row = gmorph_pkg::coord_type'(rows[i]);
            res.last_of_run = (i == rows.size() - 1) && (j == cols.size() - 1);
            res.frame_end = (cols[j] == w - 1) && (rows[i] == h - 1);
            expected_results.push_back(res);
         end
      end
      col_pos = x + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_result();
      morph_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result (%0d,%0d) value %0d with none expected",
                                   rsp_out_col, rsp_out_row, rsp_result_value));
         return;
      end
      want = expected_results.pop_front();
      if (rsp_result_value !== want.value)
         report_mismatch($sformatf("value at (%0d,%0d): got %0d, expected %0d",
                                   want.col, want.row, rsp_result_value, want.value));
      if (rsp_out_col !== want.col)
         report_mismatch($sformatf("column: got %0d, expected %0d", rsp_out_col, want.col));
      if (rsp_out_row !== want.row)
         report_mismatch($sformatf("row: got %0d, expected %0d", rsp_out_row, want.row));
      if (rsp_last_of_run !== want.last_of_run)
         report_mismatch($sformatf("last_of_run at (%0d,%0d): got %b, expected %b",
                                   want.col, want.row, rsp_last_of_run, want.last_of_run));
      if (rsp_frame_end !== want.frame_end)
         report_mismatch($sformatf("frame_end at (%0d,%0d): got %b, expected %b",
                                   want.col, want.row, rsp_frame_end, want.frame_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = gmorph_pkg::WIDTH_RESET;
         height_reg = gmorph_pkg::HEIGHT_RESET;
         erode_reg = 1'b0;
         col_pos = 0;
         row_pos = 0;
         window = '{default: '0};
         expected_results.delete();
      end else begin
         if (csr_write) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall) predict_neighborhoods(req_pixel);
         if (rsp_valid && !rsp_stall) check_result();
      end
      outstanding <= expected_results.size();
   end

endmodule

// ===== tb/gray_morphology_3x3_test.sv =====
`timescale 1ns / 100ps
module gray_morphology_3x3_test;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PIXELS = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [gmorph_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   gmorph_pkg::pixel_type              req_pixel = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   gmorph_pkg::pixel_type              rsp_result_value;
   gmorph_pkg::coord_type              rsp_out_col;
   gmorph_pkg::coord_type              rsp_out_row;
   logic                               rsp_last_of_run;
   logic                               rsp_frame_end;
   logic                               csr_write = 1'b0;
   logic [gmorph_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   gmorph_pkg::cfg_type                csr_data = '0;

   int mismatches;
   int outstanding;
   int send_idle_pct = 19;
   int recv_idle_pct = 57;
   int cycle_count = 0;

   gray_morphology_3x3 DUT (.*);

   gray_morphology_3x3_checker morph_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("gray_morphology_3x3: mismatch");
         $finish;
      end
   end

   task automatic send_pixel(gmorph_pkg::pixel_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [gmorph_pkg::CSR_INDEX_W-1:0] index,
                          gmorph_pkg::cfg_type data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
   endtask

   function automatic gmorph_pkg::cfg_type erode_word(logic erode);
      gmorph_pkg::cfg_type word;
      word = gmorph_pkg::cfg_type'($urandom_range(0, 4095));
      word[0] = erode;
      return word;
   endfunction

   task automatic set_frame(int w, int h, logic erode);
      wait_idle();
      csr_put(gmorph_pkg::CSR_FRAME_WIDTH, gmorph_pkg::cfg_type'(w));
      csr_put(gmorph_pkg::CSR_FRAME_HEIGHT, gmorph_pkg::cfg_type'(h));
      csr_put(gmorph_pkg::CSR_ERODE_MODE, erode_word(erode));
      csr_write <= 1'b0;
   endtask

   initial begin
      gmorph_pkg::pixel_type pattern [9];
      int random_pixels;
      int w, h, n;
      logic erode;

      pattern = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd0, 8'd255, 8'd1, 8'd254, 8'd0};
      random_pixels = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full 3x3 frames, both modes
      set_frame(3, 3, 1'b0);
      foreach (pattern[i]) send_pixel(pattern[i]);
      set_frame(3, 3, 1'b1);
      foreach (pattern[i]) send_pixel(pattern[i]);

      // zero sizes act as a single pixel frame
      set_frame(0, 0, 1'b0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd127);

      // unknown register index is ignored
      wait_idle();
      csr_put(CSR_UNUSED, 12'hFFF);
      csr_write <= 1'b0;
      send_pixel(8'd200);
      send_pixel(8'd55);

      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels < RANDOM_PIXELS / 3) begin
            send_idle_pct = 19;
            recv_idle_pct = 57;
         end else if (random_pixels < 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         erode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: begin
               // wide rows, single row frame
               case ($urandom_range(0, 3))
                  0: w = 2048;
                  1: w = 4095;
                  2: w = 2047;
                  default: w = $urandom_range(9, 4095);
               endcase
               h = $urandom_range(0, 1);
               n = $urandom_range(10, 40);
            end
            1: begin
               // tall frame, only its top part
               w = $urandom_range(1, 4);
               case ($urandom_range(0, 2))
                  0: h = 2048;
                  1: h = 4095;
                  default: h = $urandom_range(9, 4095);
               endcase
               n = $urandom_range(10, 40);
            end
            2: begin
               // frame that may be cut short by a restart
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 6);
               n = $urandom_range(1, w * h);
            end
            default: begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 6);
               n = w * h * $urandom_range(1, 2);
            end
         endcase
         set_frame(w, h, erode);
         for (int i = 0; i < n; i++) begin
            send_pixel(gmorph_pkg::pixel_type'($urandom_range(0, 255)));
            if ($urandom_range(0, 29) == 0) begin
               wait_idle();
               if ($urandom_range(0, 1) == 1) begin
                  csr_put(gmorph_pkg::CSR_ERODE_MODE, erode_word(1'($urandom_range(0, 1))));
                  csr_write <= 1'b0;
               end
            end
         end
         random_pixels += n;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("gray_morphology_3x3: match");
      end else begin
         $display("gray_morphology_3x3: mismatch");
      end
      $finish;
   end

endmodule
